@@ rtl/core/gradient_edge_threshold_assert.svh @@
// Assertion macros for the gradient edge threshold block.
// Used at the end of the top level; expects clk and rst_n in scope.
`ifndef GRADIENT_EDGE_THRESHOLD_ASSERT_SVH
`define GRADIENT_EDGE_THRESHOLD_ASSERT_SVH

// Check a property while out of reset.
`define GET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define GET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/get_pkg.sv @@
// Shared constants, types and register codes for the gradient edge threshold block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package get_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W = 8;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Configuration register widths
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int THR_W        = 22;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = THR_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd3;

  // Kernel modes
  localparam logic KERNEL_SOBEL   = 1'b0;
  localparam logic KERNEL_PREWITT = 1'b1;

  // Reset values
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = WIDTH_CFG_W'(640);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = HEIGHT_CFG_W'(480);

  // Clamp limits
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_MIN  = WIDTH_CFG_W'(3);
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_MAX  = WIDTH_CFG_W'(MAX_WIDTH);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_MIN = HEIGHT_CFG_W'(3);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_MAX = HEIGHT_CFG_W'(MAX_HEIGHT);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

endpackage

`default_nettype wire

@@ rtl/core/get_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the line stores of the gradient edge threshold block.
`timescale 1ns / 1ps
`default_nettype none

module get_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/gradient_edge_threshold.sv @@
// Top level of the 3x3 Sobel/Prewitt edge detector with squared-magnitude threshold.
// Depends on get_pkg, get_ram and gradient_edge_threshold_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Streams 8-bit grayscale pixels in raster order, one per clock unless stalled, and returns
// one edge flag for every pixel that completes a full 3x3 window, so a frame
// of H rows by W columns yields (H-2)x(W-2) results, the last one carrying
// end_of_frame. start_of_frame restarts the row and column count at that pixel.
// Sustained rate is one pixel per cycle while out_stall stays low; a result is
// registered through the line store read at the accepting edge, then window
// update, then gradient and threshold. Each line store RAM does one read and one write per cycle,
// and a bypass covers a column that is revisited right away after an early
// start_of_frame. Line stores need no clearing after reset: a full window
// only reads entries written earlier in the same frame. Write configuration
// only while no pixel is in flight; cfg_ready is always high.

module gradient_edge_threshold (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [get_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          in_start_of_frame,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_edge_res,
  output logic                          out_end_of_frame,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [get_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [get_pkg::CFG_DATA_W-1:0] cfg_data
);

  import get_pkg::*;

  // Configuration
  logic                    kernel_mode_r;
  logic [WIDTH_CFG_W-1:0]  image_width_r;
  logic [HEIGHT_CFG_W-1:0] image_height_r;
  logic [THR_W-1:0]        threshold_r;
  col_t                    wm1;
  row_t                    hm1;

  // Counters
  col_t col_r, col_nxt, col_cur;
  row_t row_r, row_nxt, row_cur;

  // Stage A: line store read
  logic a_v_r, a_full_r, a_eof_r, a_fwd_r;
  pix_t a_px_r, a_fwd_up_r, a_fwd_mid_r;
  col_t a_addr_r;
  pix_t up_rd, mid_rd, up_eff, mid_eff;

  // Stage B: window
  logic b_v_r, b_full_r, b_eof_r;
  pix_t win_r [3][3];

  // Stage C: result
  logic out_v_r, out_edge_r, out_eof_r;

  logic rdy_a, rdy_b, rdy_c, in_acc, a_adv, hit;

  logic signed [10:0] gx, gy, tx1, ty1;
  logic [9:0]         gx_abs, gy_abs;
  logic [19:0]        sqx, sqy;
  logic [20:0]        mag;
  logic               is_edge;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r  <= KERNEL_SOBEL;
      image_width_r  <= WIDTH_RST;
      image_height_r <= HEIGHT_RST;
      threshold_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KERNEL_MODE:  kernel_mode_r  <= cfg_data[0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WIDTH_CFG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[HEIGHT_CFG_W-1:0];
        CFG_THRESHOLD:    threshold_r    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Last column and last row, after clamping the registers
  always_comb begin
    if (image_width_r < WIDTH_MIN) begin
      wm1 = COL_W'(2);
    end else if (image_width_r > WIDTH_MAX) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(image_width_r - WIDTH_CFG_W'(1));
    end
    if (image_height_r < HEIGHT_MIN) begin
      hm1 = ROW_W'(2);
    end else if (image_height_r > HEIGHT_MAX) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(image_height_r - HEIGHT_CFG_W'(1));
    end
  end

  // Stage readiness: a stage takes a beat when empty or when it drains
  assign rdy_c    = !out_v_r || !out_stall;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign in_stall = !rdy_a;
  assign in_acc   = in_valid && rdy_a;
  assign a_adv    = a_v_r && rdy_b;

  always_comb begin
    col_cur = in_start_of_frame ? '0 : col_r;
    row_cur = in_start_of_frame ? '0 : row_r;
    if (col_cur >= wm1) begin
      col_nxt = '0;
      row_nxt = (row_cur >= hm1) ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  get_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_addr_r),
    .wdata (mid_eff),
    .re    (in_acc),
    .raddr (col_cur),
    .rdata (up_rd)
  );

  get_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_addr_r),
    .wdata (a_px_r),
    .re    (in_acc),
    .raddr (col_cur),
    .rdata (mid_rd)
  );

  // Bypass the RAM when the column being written is read in the same cycle
  assign up_eff  = a_fwd_r ? a_fwd_up_r  : up_rd;
  assign mid_eff = a_fwd_r ? a_fwd_mid_r : mid_rd;
  assign hit     = a_adv && (a_addr_r == col_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (rdy_a) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_px_r      <= in_pixel;
      a_addr_r    <= col_cur;
      a_full_r    <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      a_eof_r     <= (row_cur >= hm1) && (col_cur >= wm1);
      a_fwd_r     <= hit;
      a_fwd_up_r  <= mid_eff;
      a_fwd_mid_r <= a_px_r;
    end
  end

  // Stage B: shift the window left and load the newest column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (rdy_b) begin
        b_v_r <= a_v_r;
      end
      if (a_adv) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= up_eff;
        win_r[1][2] <= mid_eff;
        win_r[2][2] <= a_px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_full_r <= a_full_r;
      b_eof_r  <= a_eof_r;
    end
  end

  // Stage C: gradients, squared magnitude, threshold
  always_comb begin
    tx1 = $signed({3'b000, win_r[1][2]}) - $signed({3'b000, win_r[1][0]});
    ty1 = $signed({3'b000, win_r[2][1]}) - $signed({3'b000, win_r[0][1]});
    if (kernel_mode_r == KERNEL_SOBEL) begin
      tx1 = tx1 <<< 1;
      ty1 = ty1 <<< 1;
    end
    gx = $signed({3'b000, win_r[0][2]}) - $signed({3'b000, win_r[0][0]}) + tx1
       + $signed({3'b000, win_r[2][2]}) - $signed({3'b000, win_r[2][0]});
    gy = $signed({3'b000, win_r[2][0]}) - $signed({3'b000, win_r[0][0]}) + ty1
       + $signed({3'b000, win_r[2][2]}) - $signed({3'b000, win_r[0][2]});
    gx_abs  = gx[10] ? 10'(-gx) : gx[9:0];
    gy_abs  = gy[10] ? 10'(-gy) : gy[9:0];
    sqx     = {10'd0, gx_abs} * {10'd0, gx_abs};
    sqy     = {10'd0, gy_abs} * {10'd0, gy_abs};
    mag     = {1'b0, sqx} + {1'b0, sqy};
    is_edge = {1'b0, mag} >= threshold_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_c) begin
      // drop beats that do not complete a full window
      out_v_r <= b_v_r && b_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_v_r && rdy_c) begin
      out_edge_r <= is_edge;
      out_eof_r  <= b_eof_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_edge_res     = out_edge_r;
  assign out_end_of_frame = out_eof_r;

`include "gradient_edge_threshold_assert.svh"

  `GET_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `GET_ASSERT(a_window_holds, b_v_r && !rdy_c |=> b_v_r && $stable(b_eof_r), "window stage lost a beat")
  `GET_ASSERT(a_empty_takes, !a_v_r |-> !in_stall, "input stalled with empty read stage")

endmodule

`default_nettype wire

@@ tb/gradient_edge_threshold_test.sv @@
// Self-checking testbench for the 3x3 Sobel/Prewitt edge detector: a directed table, then
// random frames under random register settings, checked against a window model of the block.
// Depends on get_pkg and the gradient_edge_threshold RTL.
`timescale 1ns / 1ps

module gradient_edge_threshold_test;
  import get_pkg::*;

  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic edge_flag;
    logic frame_last;
  } edge_result_t;

  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    pix_t                  px;
    logic                  sof;
    logic                  typed;
    edge_result_t          want;
  } plan_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {PIX_NOISE, PIX_RAMP, PIX_BINARY} pix_style_t;

  localparam edge_result_t          NO_RESULT = '0;
  localparam logic [CFG_DATA_W-1:0] DATA_ZERO = '0;
  localparam logic [CFG_DATA_W-1:0] DATA_ONES = '1;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pix_t                  in_pixel = '0;
  logic                  in_start_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_edge_res;
  logic                  out_end_of_frame;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow registers and window state of the edge model
  logic                    kernel_prewitt;
  logic [WIDTH_CFG_W-1:0]  width_reg;
  logic [HEIGHT_CFG_W-1:0] height_reg;
  logic [THR_W-1:0]        thr_reg;
  pix_t                    upper_line [MAX_WIDTH];
  pix_t                    middle_line [MAX_WIDTH];
  bit                      upper_set [MAX_WIDTH];
  bit                      middle_set [MAX_WIDTH];
  pix_t                    win [3][3];
  col_t                    col_cnt;
  row_t                    row_cnt;

  edge_result_t edges_due[$];
  int           mismatch_count = 0;
  int           burst_left = 0;
  int           stall_left = 0;
  stall_mode_t  stall_mode = STALL_NONE;
  bit           gapless = 1'b0;

  // Three tiny frames: clamped 3x3 size, both kernels, threshold zero, max and equal.
  plan_row_t directed_plan [0:35] = '{
    '{1'b1, CFG_IMAGE_WIDTH,  DATA_ZERO, 8'd0, 1'b0, 1'b0, NO_RESULT},
    '{1'b1, CFG_IMAGE_HEIGHT, DATA_ZERO, 8'd0, 1'b0, 1'b0, NO_RESULT},
    '{1'b1, CFG_KERNEL_MODE,  CFG_DATA_W'(KERNEL_SOBEL), 8'd0, 1'b0, 1'b0, NO_RESULT},
    '{1'b1, CFG_THRESHOLD,    DATA_ZERO, 8'd0, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b1, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b1, '{1'b1, 1'b1}},
    '{1'b1, CFG_KERNEL_MODE,  CFG_DATA_W'(KERNEL_PREWITT), 8'd0, 1'b0, 1'b0, NO_RESULT},
    '{1'b1, CFG_THRESHOLD,    DATA_ONES, 8'd0, 1'b0, 1'b0, NO_RESULT},
    // no start mark: the counters wrapped at the end of the last frame
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd128, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd128, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd128, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b1, '{1'b0, 1'b1}},
    '{1'b1, CFG_KERNEL_MODE,  CFG_DATA_W'(KERNEL_SOBEL), 8'd0, 1'b0, 1'b0, NO_RESULT},
    '{1'b1, CFG_THRESHOLD,    CFG_DATA_W'(1040400), 8'd0, 1'b0, 1'b0, NO_RESULT},
    // start mark again one pixel into the frame
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd77,  1'b1, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b1, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd0,   1'b0, 1'b0, NO_RESULT},
    // squared gradient magnitude lands exactly on the threshold
    '{1'b0, CFG_KERNEL_MODE,  DATA_ZERO, 8'd255, 1'b0, 1'b1, '{1'b1, 1'b1}}
  };

  gradient_edge_threshold i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_edge_res      (out_edge_res),
    .out_end_of_frame  (out_end_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  function automatic int clamp_width(input logic [WIDTH_CFG_W-1:0] v);
    if (v < WIDTH_MIN) return int'(WIDTH_MIN);
    if (v > WIDTH_MAX) return int'(WIDTH_MAX);
    return int'(v);
  endfunction

  function automatic int clamp_height(input logic [HEIGHT_CFG_W-1:0] v);
    if (v < HEIGHT_MIN) return int'(HEIGHT_MIN);
    if (v > HEIGHT_MAX) return int'(HEIGHT_MAX);
    return int'(v);
  endfunction

  // Both line stores hold data written since reset for every column below w.
  function automatic bit stores_ready(input int w);
    for (int c = 0; c < w; c++) begin
      if (!upper_set[c] || !middle_set[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Push one pixel through the window; return 1 when it completes a full window.
  function automatic bit detect_edge(input pix_t px, input logic sof, output edge_result_t res);
    int   w;
    int   h;
    int   wt;
    int   gx;
    int   gy;
    int   mag;
    pix_t up;
    pix_t mid;
    bit   produced;
    w = clamp_width(width_reg);
    h = clamp_height(height_reg);
    produced = 1'b0;
    res = NO_RESULT;
    if (sof) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    up = upper_line[col_cnt];
    mid = middle_line[col_cnt];
    upper_line[col_cnt] = mid;
    middle_line[col_cnt] = px;
    upper_set[col_cnt] = middle_set[col_cnt];
    middle_set[col_cnt] = 1'b1;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;
    if (row_cnt >= 2 && col_cnt >= 2) begin
      wt = (kernel_prewitt == KERNEL_PREWITT) ? 1 : 2;
      gx = (int'(win[0][2]) - int'(win[0][0])) + wt * (int'(win[1][2]) - int'(win[1][0]))
         + (int'(win[2][2]) - int'(win[2][0]));
      gy = (int'(win[2][0]) - int'(win[0][0])) + wt * (int'(win[2][1]) - int'(win[0][1]))
         + (int'(win[2][2]) - int'(win[0][2]));
      mag = gx * gx + gy * gy;
      res.edge_flag = (mag >= int'(thr_reg));
      res.frame_last = (int'(row_cnt) >= h - 1) && (int'(col_cnt) >= w - 1);
      produced = 1'b1;
    end
    // A counter at or past the end also closes the row, even after a register was lowered
    if (int'(col_cnt) >= w - 1) begin
      col_cnt = '0;
      if (int'(row_cnt) >= h - 1) row_cnt = '0;
      else row_cnt = row_cnt + row_t'(1);
    end else begin
      col_cnt = col_cnt + col_t'(1);
    end
    return produced;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_pixel(input pix_t px, input logic sof, input logic typed,
                            input edge_result_t typed_res);
    int           gap;
    edge_result_t res;
    bit           produced;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    in_start_of_frame <= sof;
    do @(posedge clk); while (in_stall);
    burst_left--;
    produced = detect_edge(px, sof, res);
    if (typed) edges_due.push_back(typed_res);
    else if (produced) edges_due.push_back(res);
  endtask

  // Hold valid high across back-to-back writes; the caller drops it after the last one.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KERNEL_MODE:  kernel_prewitt = data[0];
      CFG_IMAGE_WIDTH:  width_reg = data[WIDTH_CFG_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = data[HEIGHT_CFG_W-1:0];
      CFG_THRESHOLD:    thr_reg = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Drain every pending result, then wait out pixels that make no result.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 5 < 2);
    endcase
  end

  always @(posedge clk) begin
    edge_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (edges_due.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending (edge %b, eof %b)",
                                  out_edge_res, out_end_of_frame));
      end else begin
        want = edges_due.pop_front();
        if (out_edge_res !== want.edge_flag)
          report_mismatch($sformatf("edge_res got %b want %b", out_edge_res, want.edge_flag));
        if (out_end_of_frame !== want.frame_last)
          report_mismatch($sformatf("end_of_frame got %b want %b", out_end_of_frame,
                                    want.frame_last));
      end
    end
  end

  initial begin
    plan_row_t             row;
    bit                    cfg_open;
    int                    sent;
    int                    phase_len;
    int                    old_w;
    logic [3:0]            pick;
    logic [CFG_DATA_W-1:0] d;
    logic                  start_frame;
    logic                  sof;
    pix_t                  px;
    pix_t                  prev_px;
    pix_style_t            style;

    kernel_prewitt = KERNEL_SOBEL;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    thr_reg = '0;
    col_cnt = '0;
    row_cnt = '0;
    foreach (win[r, c]) win[r][c] = '0;
    foreach (upper_line[c]) begin
      upper_line[c] = '0;
      middle_line[c] = '0;
      upper_set[c] = 1'b0;
      middle_set[c] = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    cfg_open = 1'b0;
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_reg) begin
        if (!cfg_open) quiesce();
        cfg_open = 1'b1;
        put_reg(row.reg_idx, row.reg_data);
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        send_pixel(row.px, row.sof, row.typed, row.want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiesce();
      old_w = clamp_width(width_reg);
      pick = 4'($urandom_range(1, 15));
      if (pick[0]) put_reg(CFG_KERNEL_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      if (pick[1]) begin
        case ($urandom_range(0, 19))
          0, 1:    d = CFG_DATA_W'($urandom_range(0, 2));
          2:       d = CFG_DATA_W'($urandom_range(1024, 2047));
          3:       d = CFG_DATA_W'($urandom_range(0, 2047));
          4:       d = CFG_DATA_W'($urandom_range(11, 64));
          default: d = CFG_DATA_W'($urandom_range(3, 10));
        endcase
        put_reg(CFG_IMAGE_WIDTH, d);
      end
      if (pick[2]) begin
        case ($urandom_range(0, 15))
          0, 1:    d = CFG_DATA_W'($urandom_range(0, 2));
          2:       d = CFG_DATA_W'(MAX_HEIGHT);
          3:       d = CFG_DATA_W'({HEIGHT_CFG_W{1'b1}});
          4:       d = CFG_DATA_W'($urandom_range(9, 8191));
          default: d = CFG_DATA_W'($urandom_range(3, 8));
        endcase
        put_reg(CFG_IMAGE_HEIGHT, d);
      end
      if (pick[3]) begin
        case ($urandom_range(0, 7))
          0:       d = DATA_ZERO;
          1:       d = DATA_ONES;
          2:       d = CFG_DATA_W'($urandom_range(0, 20000));
          3:       d = CFG_DATA_W'($urandom());
          default: d = CFG_DATA_W'($urandom_range(0, 2080800));
        endcase
        put_reg(CFG_THRESHOLD, d);
      end
      cfg_valid <= 1'b0;

      // A wider row mid-frame may only reach columns the line stores already hold.
      start_frame = ($urandom_range(0, 2) == 0) ||
                    (clamp_width(width_reg) > old_w && row_cnt != 0 &&
                     !stores_ready(clamp_width(width_reg)));
      phase_len = $urandom_range(8, 160);
      gapless = ($urandom_range(0, 3) == 0);
      style = pix_style_t'($urandom_range(0, 2));
      prev_px = pix_t'($urandom());
      for (int k = 0; k < phase_len; k++) begin
        case (style)
          PIX_NOISE: px = pix_t'($urandom());
          PIX_RAMP:  px = prev_px + pix_t'($urandom_range(0, 12)) - 8'd6;
          default:   px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        endcase
        sof = (k == 0) ? start_frame : ($urandom_range(0, 149) == 0);
        send_pixel(px, sof, 1'b0, NO_RESULT);
        prev_px = px;
      end
      sent += phase_len;
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
